// ----- hw/rtl/xkc_pkg.sv -----
// Package for the xorshift keystream byte cipher.
// Holds register indexes, widths, the pipeline request struct and the xorshift step.
// No dependencies.
package xkc_pkg;

  localparam int MAX_KEY_DEF = 16;
  localparam int KEY_LEN_W   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int WORD_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN  = 3'd4;

  // Work handed from the accept stage to the keystream update stage.
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first_pass;
    logic              mode;
    logic [WORD_W-1:0] key_word;
    logic [WORD_W-1:0] addend;
  } xkc_req_t;

  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] v;
    v = x ^ (x << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

endpackage

// ----- hw/rtl/xkc_in_if.sv -----
// Input channel of the keystream cipher: one data word per handshake.
// Depends on nothing.
interface xkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

// ----- hw/rtl/xkc_out_if.sv -----
// Result channel of the keystream cipher: one transformed word per handshake.
// Depends on nothing.
interface xkc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

// ----- hw/rtl/xkc_word_update.sv -----
// Keystream word store and update stage: reads a slot's word, advances it and writes it back.
// Depends on xkc_pkg.
module xkc_word_update
  import xkc_pkg::*;
#(
  parameter int MAX_KEY = MAX_KEY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_vld,
  input  xkc_req_t                     req,
  input  logic [$clog2(MAX_KEY)-1:0]   req_slot,
  input  logic                         adv,
  output logic                         s1_vld,
  output logic [7:0]                   res_byte
);

  localparam int SLOT_W = $clog2(MAX_KEY);

  logic [WORD_W-1:0] mem [MAX_KEY];

  logic              s1_vld_r, s1_vld_nxt;
  xkc_req_t          s1_req_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [WORD_W-1:0] rdata_r;
  logic              fwd_hit_r;
  logic [WORD_W-1:0] fwd_data_r;

  logic [WORD_W-1:0] w_base;
  logic [WORD_W-1:0] w_xs;
  logic [WORD_W-1:0] w_new;
  logic              hit_now;

  // A write in the same cycle as the read of the same slot is not seen by the read.
  assign hit_now = adv && (s1_slot_r == req_slot);

  always_comb begin
    if (s1_req_r.first_pass) begin
      w_base = s1_req_r.key_word;
    end else if (fwd_hit_r) begin
      w_base = fwd_data_r;
    end else begin
      w_base = rdata_r;
    end
    w_xs  = xorshift32(w_base);
    w_new = s1_req_r.mode ? (w_xs + s1_req_r.addend) : w_xs;
  end

  always_comb begin
    if (req_vld) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      s1_req_r   <= req;
      s1_slot_r  <= req_slot;
      rdata_r    <= mem[req_slot];
      fwd_hit_r  <= hit_now;
      fwd_data_r <= w_new;
    end
    if (adv) begin
      mem[s1_slot_r] <= w_new;
    end
  end

  assign s1_vld   = s1_vld_r;
  assign res_byte = s1_req_r.data_byte ^ w_new[7:0];

endmodule

// ----- hw/rtl/xorshift_keystream_xor_cipher_top.sv -----
// Top level of the xorshift keystream byte cipher.
// Depends on xkc_pkg, xkc_in_if, xkc_out_if and xkc_word_update.
//
//  channel | direction | payload                    | handshake
//  in_ch   | in        | data_byte[7:0], first      | valid/ready
//  out_ch  | out       | out_byte[7:0]              | valid/ready
//  cfg_*   | in        | cfg_idx[2:0], cfg_data[63:0] | cfg_we, no back-pressure
//
// One word is accepted per cycle unless out_ch stalls; its result passes the update
// stage register and the output register to out_ch. The rate is set by the keystream
// word memory, read on accept and written when the update stage advances, with the
// just-written word forwarded when consecutive words hit the same slot.
// Reset (rst_n, synchronous, active low) clears the pipeline valid flags, the
// message position and the registers to their defaults; it needs no clearing pass.
// A stalled result waits in the output register while one more word is taken into
// the update stage; in_ch.ready drops only when both are full.
module xorshift_keystream_xor_cipher_top
  import xkc_pkg::*;
#(
  parameter int MAX_KEY = MAX_KEY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  xkc_in_if.sink                in_ch,
  xkc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(MAX_KEY);
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY);

  // Configuration registers.
  logic [63:0]          key_low_r;
  logic [63:0]          key_high_r;
  logic [KEY_LEN_W-1:0] key_len_r;
  logic                 mode_r;
  logic [WORD_W-1:0]    msg_len_r;

  // Message position: slot in use, byte index and first-pass flag.
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [WORD_W-1:0]    idx_r, idx_nxt;
  logic                 fp_r, fp_nxt;

  logic                 out_vld_r;
  logic [7:0]           out_byte_r;

  logic                 in_acc;
  logic                 adv;
  logic                 s1_vld;
  logic [7:0]           res_byte;

  logic [KEY_LEN_W-1:0] len_eff;
  logic [SLOT_W-1:0]    slot_cur;
  logic [SLOT_W-1:0]    slot_use;
  logic [KEY_LEN_W-1:0] slot_inc;
  logic [WORD_W-1:0]    idx_cur;
  logic                 fp_cur;
  logic [127:0]         key_all;
  xkc_req_t             req;

  // Key position (s + k) mod len. With s below len and k at most three, three
  // conditional subtractions are enough, including a one-byte key.
  function automatic logic [3:0] key_pos(input logic [SLOT_W-1:0] s,
                                         input logic [1:0] k,
                                         input logic [KEY_LEN_W-1:0] len);
    logic [KEY_LEN_W-1:0] v;
    v = KEY_LEN_W'(s) + KEY_LEN_W'(k);
    for (int i = 0; i < 3; i++) begin
      if (v >= len) begin
        v = v - len;
      end
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] key_byte(input logic [127:0] keys, input logic [3:0] j);
    return keys[{j, 3'b000} +: 8];
  endfunction

  // The update stage moves on when the output register is free or being emptied.
  assign adv          = s1_vld && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_byte = out_byte_r;

  assign key_all = {key_high_r, key_low_r};

  // Key length as used: zero counts as one, anything above the store depth saturates.
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_len_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = key_len_r;
    end
  end

  // A first mark restarts the message before this word is handled. A slot left
  // beyond a shortened key falls back to slot zero.
  always_comb begin
    slot_cur = in_ch.first ? '0 : slot_r;
    idx_cur  = in_ch.first ? '0 : idx_r;
    fp_cur   = in_ch.first ? 1'b1 : fp_r;
    slot_use = (KEY_LEN_W'(slot_cur) < len_eff) ? slot_cur : '0;
    slot_inc = KEY_LEN_W'(slot_use) + KEY_LEN_W'(1);

    req.data_byte  = in_ch.data_byte;
    req.first_pass = fp_cur;
    req.mode       = mode_r;
    req.key_word   = {key_byte(key_all, key_pos(slot_use, 2'd3, len_eff)),
                      key_byte(key_all, key_pos(slot_use, 2'd0, len_eff)),
                      key_byte(key_all, key_pos(slot_use, 2'd2, len_eff)),
                      key_byte(key_all, key_pos(slot_use, 2'd1, len_eff))};
    req.addend     = msg_len_r + idx_cur;

    slot_nxt = slot_r;
    idx_nxt  = idx_r;
    fp_nxt   = fp_r;
    if (in_acc) begin
      idx_nxt = idx_cur + WORD_W'(1);
      if (slot_inc >= len_eff) begin
        slot_nxt = '0;
        fp_nxt   = 1'b0;
      end else begin
        slot_nxt = slot_inc[SLOT_W-1:0];
        fp_nxt   = fp_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      idx_r  <= '0;
      fp_r   <= 1'b1;
    end else begin
      slot_r <= slot_nxt;
      idx_r  <= idx_nxt;
      fp_r   <= fp_nxt;
    end
  end

  // Configuration writes. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= KEY_LEN_W'(1);
      mode_r     <= 1'b0;
      msg_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LEN:  key_len_r  <= cfg_data[KEY_LEN_W-1:0];
        REG_MODE:     mode_r     <= cfg_data[0];
        REG_MSG_LEN:  msg_len_r  <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= res_byte;
    end
  end

  xkc_word_update #(
    .MAX_KEY (MAX_KEY)
  ) u_word_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_vld  (in_acc),
    .req      (req),
    .req_slot (slot_use),
    .adv      (adv),
    .s1_vld   (s1_vld),
    .res_byte (res_byte)
  );

endmodule

// ----- hw/rtl/xkc_checker.sv -----
// Port-level checker for the keystream cipher, attached to the top level by bind.
// Depends on xorshift_keystream_xor_cipher_top.
module xkc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output register");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready ##1 !out_valid) |=> out_valid)
    else $error("accepted word did not reach the output");

endmodule

bind xorshift_keystream_xor_cipher_top xkc_checker u_xkc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte)
);
